@@ hw/rtl/fsnw_pkg.sv @@
// ----------------------------------------------------------------------------
// fsnw_pkg
// Shared types and constants for the sample normalise / window filter unit.
// ----------------------------------------------------------------------------
`default_nettype none

package fsnw_pkg;

	localparam int SENSOR_W = 3;
	localparam int MV_W     = 12;
	localparam int SCALED_W = 10;
	localparam int MEAN_W   = 14;

	localparam logic [SCALED_W-1:0] FULL_SCALE = 10'd1000;

	localparam logic [MV_W-1:0] CAL_MIN_RST = 12'd200;
	localparam logic [MV_W-1:0] CAL_MAX_RST = 12'd4000;

	// configuration register indexes
	localparam logic CFG_CAL_MIN = 1'b0;
	localparam logic CFG_CAL_MAX = 1'b1;

	// classified item handed from front to back
	typedef struct packed {
		logic                err;
		logic [SENSOR_W-1:0] sensor;
		logic [SCALED_W-1:0] scaled;
	} fsnw_item_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MUL,
		F_DIV,
		F_PUSH
	} front_state_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_WRITE,
		B_LOAD,
		B_RANK,
		B_OUT
	} back_state_t;

endpackage

`default_nettype wire

@@ hw/rtl/fsnw_front.sv @@
// ----------------------------------------------------------------------------
// fsnw_front
// Accepts samples, flags bad ones and scales voltage to 0..1000 with a
// restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnw_front import fsnw_pkg::*; #(
	parameter int SENSORS = 5
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [SENSOR_W-1:0] in_sensor,
	input  wire logic [MV_W-1:0]     in_voltage,
	input  wire logic                in_failed,
	input  wire logic [MV_W-1:0]     cal_min,
	input  wire logic [MV_W-1:0]     cal_max,
	output logic                     push_valid,
	input  wire logic                push_ready,
	output fsnw_item_t               push_item
);

	localparam int NUM_W  = MV_W + SCALED_W;
	localparam int STEP_W = $clog2(SCALED_W);

	front_state_t state_q, state_d;

	logic                err_q;
	logic [SENSOR_W-1:0] sensor_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [MV_W-1:0]     d_q;
	logic [MV_W-1:0]     r_q;
	logic [NUM_W-1:0]    num_q;
	logic [NUM_W-1:0]    div_q;
	logic [STEP_W-1:0]   step_q;

	logic            bad;
	logic            low;
	logic            sat;
	logic [MV_W-1:0] diff;
	logic [MV_W-1:0] span;

	always_comb begin
		bad  = in_failed || ({2'b00, in_sensor} >= 5'(SENSORS));
		diff = in_voltage - cal_min;
		span = cal_max - cal_min;
		low  = in_voltage <= cal_min;
		sat  = (cal_max <= cal_min) || (diff >= span);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		in_ready   = 1'b0;
		push_valid = 1'b0;
		case (state_q)
			F_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (bad || low || sat) ? F_PUSH : F_MUL;
				end
			end
			F_MUL: begin
				state_d = F_DIV;
			end
			F_DIV: begin
				if (step_q == '0) begin
					state_d = F_PUSH;
				end
			end
			F_PUSH: begin
				push_valid = 1'b1;
				if (push_ready) begin
					state_d = F_IDLE;
				end
			end
			default: begin
				state_d = F_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: begin
				if (in_valid) begin
					sensor_q <= in_sensor;
					err_q    <= bad;
					d_q      <= diff;
					r_q      <= span;
					scaled_q <= (bad || low) ? '0 : (sat ? FULL_SCALE : '0);
				end
			end
			F_MUL: begin
				num_q    <= NUM_W'(d_q) * NUM_W'(FULL_SCALE);
				div_q    <= NUM_W'({r_q, {(SCALED_W-1){1'b0}}});
				step_q   <= STEP_W'(SCALED_W - 1);
				scaled_q <= '0;
			end
			F_DIV: begin
				if (num_q >= div_q) begin
					num_q    <= num_q - div_q;
					scaled_q <= {scaled_q[SCALED_W-2:0], 1'b1};
				end else begin
					scaled_q <= {scaled_q[SCALED_W-2:0], 1'b0};
				end
				div_q  <= div_q >> 1;
				step_q <= step_q - STEP_W'(1);
			end
			default: begin
			end
		endcase
	end

	assign push_item = '{err: err_q, sensor: sensor_q, scaled: scaled_q};

endmodule

`default_nettype wire

@@ hw/rtl/fsnw_queue.sv @@
// ----------------------------------------------------------------------------
// fsnw_queue
// Two-entry queue of classified items between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnw_queue import fsnw_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire fsnw_item_t in_item,
	output logic            out_valid,
	input  wire logic       out_ready,
	output fsnw_item_t      out_item
);

	fsnw_item_t ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign in_ready  = cnt_q != 2'd2;
	assign out_valid = cnt_q != 2'd0;
	assign out_item  = ent_q[rd_ptr_q];
	assign do_push   = in_valid && in_ready;
	assign do_pop    = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= in_item;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/fsnw_back.sv @@
// ----------------------------------------------------------------------------
// fsnw_back
// Window store, slot/full tracking, mean by reciprocal multiply and median
// by rank count; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module fsnw_back import fsnw_pkg::*; #(
	parameter int SENSORS = 5,
	parameter int WINDOW  = 8
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         q_valid,
	output logic              q_ready,
	input  wire fsnw_item_t   q_item,
	output logic              m_valid,
	input  wire logic         m_ready,
	output logic              m_status,
	output logic [SCALED_W-1:0] m_scaled,
	output logic [MEAN_W-1:0] m_mean,
	output logic [SCALED_W-1:0] m_median,
	output logic              m_full
);

	localparam int DEPTH  = SENSORS * WINDOW;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SLOT_W = $clog2(WINDOW);
	localparam int CNT_W  = $clog2(WINDOW + 1);
	localparam int SUM_W  = $clog2(1000 * WINDOW + 1);
	localparam int X_W    = SUM_W + 4;
	localparam int SH     = X_W + SLOT_W;
	localparam int REC_W  = X_W + 1;
	localparam int PROD_W = X_W + REC_W;
	localparam int HALF   = WINDOW / 2;
	localparam logic [REC_W-1:0] RECIP = REC_W'(((1 << SH) + WINDOW - 1) / WINDOW);

	back_state_t state_q, state_d;

	logic [SCALED_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]    vld_q;
	logic [SCALED_W-1:0] rd_data_s1;
	logic                rd_vld_s1;

	fsnw_item_t          item_q;
	logic [SLOT_W-1:0]   slot_q;
	logic                full_q;
	logic [CNT_W-1:0]    k_q;
	logic [SLOT_W-1:0]   c_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SCALED_W-1:0] win_q [WINDOW];
	logic [SCALED_W-1:0] med_q;
	logic [PROD_W-1:0]   prod_q;
	logic                stats_q;
	logic                m_valid_q;

	logic [ADDR_W-1:0]   base;
	logic [ADDR_W-1:0]   wr_addr;
	logic [ADDR_W-1:0]   rd_addr;
	logic                wr_en;
	logic                last;
	logic                full_n;
	logic [SCALED_W-1:0] rd_val;
	logic [CNT_W-1:0]    kprev;
	logic [SCALED_W-1:0] cand;
	logic [CNT_W-1:0]    lt_cnt;
	logic [CNT_W-1:0]    le_cnt;
	logic                out_load;

	always_comb begin
		base    = ADDR_W'(item_q.sensor) * ADDR_W'(WINDOW);
		wr_addr = base + ADDR_W'(slot_q);
		rd_addr = base + ADDR_W'(k_q[SLOT_W-1:0]);
		last    = {2'b00, item_q.sensor} == 5'(SENSORS - 1);
		full_n  = full_q || (last && (slot_q == SLOT_W'(WINDOW - 1)));
		wr_en   = (state_q == B_WRITE) && !item_q.err;
		rd_val  = rd_vld_s1 ? rd_data_s1 : '0;
		kprev   = k_q - CNT_W'(1);
		cand    = win_q[c_q];
		lt_cnt  = '0;
		le_cnt  = '0;
		for (int j = 0; j < WINDOW; j++) begin
			lt_cnt = lt_cnt + CNT_W'(win_q[j] < cand);
			le_cnt = le_cnt + CNT_W'(win_q[j] <= cand);
		end
		out_load = (state_q == B_OUT) && (!m_valid_q || m_ready);
	end

	// window store
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= item_q.scaled;
		end
		rd_data_s1 <= mem[rd_addr];
		rd_vld_s1  <= vld_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			vld_q     <= '0;
			slot_q    <= '0;
			full_q    <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
				if (last) begin
					slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 :
						SLOT_W'(slot_q + SLOT_W'(1));
					full_q <= full_n;
				end
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_ready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		case (state_q)
			B_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					state_d = B_WRITE;
				end
			end
			B_WRITE: begin
				state_d = (!item_q.err && full_n) ? B_LOAD : B_OUT;
			end
			B_LOAD: begin
				if (k_q == CNT_W'(WINDOW)) begin
					state_d = B_RANK;
				end
			end
			B_RANK: begin
				if (c_q == SLOT_W'(WINDOW - 1)) begin
					state_d = B_OUT;
				end
			end
			B_OUT: begin
				if (!m_valid_q || m_ready) begin
					state_d = B_IDLE;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (q_valid) begin
					item_q <= q_item;
				end
			end
			B_WRITE: begin
				stats_q <= !item_q.err && full_n;
				k_q     <= '0;
				c_q     <= '0;
				sum_q   <= '0;
			end
			B_LOAD: begin
				k_q <= k_q + CNT_W'(1);
				if (k_q != '0) begin
					win_q[kprev[SLOT_W-1:0]] <= rd_val;
					sum_q <= sum_q + SUM_W'(rd_val);
				end
			end
			B_RANK: begin
				c_q    <= c_q + SLOT_W'(1);
				prod_q <= PROD_W'({sum_q, 4'b0000}) * PROD_W'(RECIP);
				if ((lt_cnt <= CNT_W'(HALF)) && (le_cnt > CNT_W'(HALF))) begin
					med_q <= cand;
				end
			end
			default: begin
			end
		endcase
		if (out_load) begin
			m_status <= item_q.err;
			m_scaled <= item_q.scaled;
			m_mean   <= stats_q ? MEAN_W'(prod_q >> SH) : '0;
			m_median <= stats_q ? med_q : '0;
			m_full   <= full_q;
		end
	end

	assign m_valid = m_valid_q;

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		slot_q <= SLOT_W'(WINDOW - 1))
		else $error("write slot out of range");

	a_full_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		full_q |=> full_q)
		else $error("full flag dropped");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_status) |-> (m_scaled == '0 && m_mean == '0 && m_median == '0))
		else $error("error result carries data");

	a_notfull_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_full) |-> (m_mean == '0 && m_median == '0))
		else $error("statistics before window full");

endmodule

`default_nettype wire

@@ hw/rtl/flex_sample_normalize_window_filter_unit.sv @@
// ----------------------------------------------------------------------------
// flex_sample_normalize_window_filter_unit
// Per-sensor sample normaliser with sliding window mean and upper median.
// ----------------------------------------------------------------------------
// Each transaction is one sensor sample. The front scales it to 0..1000 with
// a bit-serial divider (10 quotient bits) and passes it through a two-entry
// queue to the back. The back writes the window store and, once the window
// is full, reads that sensor's WINDOW slots (one per cycle from the store)
// and ranks them one candidate per cycle; error items and items before the
// window is full skip the read and rank steps. Once the window is full, the
// back's sweep sets the sustained rate. The store is cleared at reset by
// per-entry valid bits, with no clearing pass.
`default_nettype none

module flex_sample_normalize_window_filter_unit import fsnw_pkg::*; #(
	parameter int SENSORS = 5,
	parameter int WINDOW  = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [11:0] cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // sensor[2:0], voltage_mv[14:3], zero pad
	input  wire logic [0:0]  s_tuser,  // read_failed
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // scaled_value[9:0], mean_x16[23:10],
	                                   // median_value[33:24], zero pad
	output logic [1:0]       m_tuser   // status, window_full
);

	logic [MV_W-1:0] cal_min_q;
	logic [MV_W-1:0] cal_max_q;

	logic       push_valid;
	logic       push_ready;
	fsnw_item_t push_item;
	logic       pop_valid;
	logic       pop_ready;
	fsnw_item_t pop_item;

	logic                m_status;
	logic [SCALED_W-1:0] m_scaled;
	logic [MEAN_W-1:0]   m_mean;
	logic [SCALED_W-1:0] m_median;
	logic                m_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal_min_q <= CAL_MIN_RST;
			cal_max_q <= CAL_MAX_RST;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_CAL_MIN: cal_min_q <= cfg_wdata;
				CFG_CAL_MAX: cal_max_q <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	fsnw_front #(
		.SENSORS(SENSORS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_sensor  (s_tdata[2:0]),
		.in_voltage (s_tdata[14:3]),
		.in_failed  (s_tuser[0]),
		.cal_min    (cal_min_q),
		.cal_max    (cal_max_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	fsnw_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (push_valid),
		.in_ready  (push_ready),
		.in_item   (push_item),
		.out_valid (pop_valid),
		.out_ready (pop_ready),
		.out_item  (pop_item)
	);

	fsnw_back #(
		.SENSORS(SENSORS),
		.WINDOW (WINDOW)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_ready  (pop_ready),
		.q_item   (pop_item),
		.m_valid  (m_tvalid),
		.m_ready  (m_tready),
		.m_status (m_status),
		.m_scaled (m_scaled),
		.m_mean   (m_mean),
		.m_median (m_median),
		.m_full   (m_full)
	);

	assign m_tdata = {6'b000000, m_median, m_mean, m_scaled};
	assign m_tuser = {m_full, m_status};

endmodule

`default_nettype wire
